FILE: rtl/scr_pkg.sv
// shared types, codes and helpers for the serial command responder
package scr_pkg;

    localparam int PayloadLen = 12;
    localparam int NumAxes    = 3;

    localparam logic [7:0] CharInit  = 8'h49; // 'I'
    localparam logic [7:0] CharHome  = 8'h48; // 'H'
    localparam logic [7:0] CharTemp  = 8'h54; // 'T'
    localparam logic [7:0] CharCurr  = 8'h43; // 'C'
    localparam logic [7:0] CharAngle = 8'h50; // 'P'
    localparam logic [7:0] CharRef   = 8'h52; // 'R'
    localparam logic [7:0] LowByteMask = 8'hFF;

    typedef enum logic [2:0] {
        REQ_RX_BYTE   = 3'd0,
        REQ_HOME_SW   = 3'd1,
        REQ_TEMP      = 3'd2,
        REQ_CURRENT   = 3'd3,
        REQ_ANGLE     = 3'd4,
        REQ_HOME_DONE = 3'd5
    } req_type_t;

    typedef enum logic [2:0] {
        CMD_NONE,
        CMD_INIT,
        CMD_HOME,
        CMD_TEMP,
        CMD_CURR,
        CMD_ANGLE,
        CMD_REF
    } cmd_t;

    typedef enum logic [2:0] {
        RPL_INIT,
        RPL_HOME,
        RPL_TEMP,
        RPL_CURR,
        RPL_ANGLE,
        RPL_REF
    } reply_t;

    typedef enum logic {
        ST_IDLE,
        ST_SEND
    } state_t;

    typedef struct packed {
        logic [2:0]  req_type;
        logic [1:0]  axis;
        logic [31:0] sensor_word;
        logic [7:0]  rx_byte;
    } in_item_t;

    typedef struct packed {
        logic        tx_valid;
        logic [7:0]  tx_byte;
        logic        ref_valid;
        logic [31:0] angle_ref_one;
        logic [31:0] angle_ref_two;
        logic        close_cmd;
        logic        open_cmd;
        logic        homing_request;
        logic        last;
    } out_item_t;

    // datapath to controller
    typedef struct packed {
        logic is_rx;
        cmd_t cmd;
        logic initialized;
        logic out_free;
    } dp_status_t;

    // controller to datapath
    typedef struct packed {
        logic       take;
        logic       pay_wr;
        logic [3:0] pay_idx;
        logic       apply;
        logic       clear_init;
        logic       load_out;
        reply_t     reply;
        logic [3:0] idx;
        logic       last;
    } dp_ctrl_t;

    function automatic cmd_t decode_cmd(input logic [7:0] b);
        cmd_t c;
        case (b)
            CharInit:  c = CMD_INIT;
            CharHome:  c = CMD_HOME;
            CharTemp:  c = CMD_TEMP;
            CharCurr:  c = CMD_CURR;
            CharAngle: c = CMD_ANGLE;
            CharRef:   c = CMD_REF;
            default:   c = CMD_NONE;
        endcase
        return c;
    endfunction

    function automatic logic [3:0] reply_len(input reply_t r);
        logic [3:0] n;
        case (r)
            RPL_HOME, RPL_TEMP:  n = 4'd3;
            RPL_CURR, RPL_ANGLE: n = 4'd12;
            default:             n = 4'd1;
        endcase
        return n;
    endfunction

endpackage

FILE: rtl/serial_command_responder_core.sv
// top level of the serial command responder
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+---------------------------------
//  s_      | in  | s_valid / s_ready  | s_data: req_type, axis, sensor_word, rx_byte
//  m_      | out | m_valid / m_ready  | m_data: tx, reference and gripper fields, last
//
// an item that gives no result leaves the controller ready for the next item; one that gives
// n results sends them one result per cycle unless m_ready stalls, paced by the reply sequencer in the controller
// s_ready is low while a reply is being loaded into the output register
// a stall on m_ready holds the reply sequencer; the last result may wait while
// the next item is taken
// synchronous active-low reset clears control state, sensor stores and references
module serial_command_responder_core (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  scr_pkg::in_item_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output scr_pkg::out_item_t m_data
);
    import scr_pkg::*;

    dp_status_t status;
    dp_ctrl_t   ctrl;

    scr_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .ctrl    (ctrl)
    );

    scr_dp u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .ctrl    (ctrl),
        .status  (status),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

FILE: rtl/scr_ctrl.sv
// controller: receive phase, command dispatch and reply sequencing
module scr_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  scr_pkg::dp_status_t status,
    output scr_pkg::dp_ctrl_t   ctrl
);
    import scr_pkg::*;

    state_t     state_reg, state_next;
    reply_t     reply_reg, reply_next;
    logic [3:0] idx_reg, idx_next;
    logic [3:0] phase_reg, phase_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            reply_reg <= RPL_INIT;
            idx_reg   <= '0;
            phase_reg <= '0;
        end else begin
            state_reg <= state_next;
            reply_reg <= reply_next;
            idx_reg   <= idx_next;
            phase_reg <= phase_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        reply_next = reply_reg;
        idx_next   = idx_reg;
        phase_next = phase_reg;
        s_ready    = (state_reg == ST_IDLE);

        ctrl            = '0;
        ctrl.take       = s_valid && s_ready;
        ctrl.reply      = reply_reg;
        ctrl.idx        = idx_reg;
        ctrl.pay_idx    = phase_reg - 4'd1;
        ctrl.last       = (idx_reg == reply_len(reply_reg) - 4'd1);

        case (state_reg)
            ST_IDLE: begin
                if (ctrl.take && status.is_rx) begin
                    idx_next = '0;
                    if (phase_reg inside {[4'd1:4'd12]}) begin
                        ctrl.pay_wr = 1'b1;
                        if (phase_reg == 4'(PayloadLen)) begin
                            phase_next = '0;
                            if (status.initialized) begin
                                ctrl.apply = 1'b1;
                                reply_next = RPL_REF;
                                state_next = ST_SEND;
                            end
                        end else begin
                            phase_next = phase_reg + 4'd1;
                        end
                    end else begin
                        phase_next = '0;
                        case (status.cmd)
                            CMD_INIT: begin
                                ctrl.clear_init = 1'b1;
                                reply_next = RPL_INIT;
                                state_next = ST_SEND;
                            end
                            CMD_HOME: begin
                                reply_next = RPL_HOME;
                                state_next = ST_SEND;
                            end
                            CMD_TEMP: begin
                                reply_next = RPL_TEMP;
                                state_next = ST_SEND;
                            end
                            CMD_CURR: begin
                                reply_next = RPL_CURR;
                                state_next = ST_SEND;
                            end
                            CMD_ANGLE: begin
                                reply_next = RPL_ANGLE;
                                state_next = ST_SEND;
                            end
                            CMD_REF:  phase_next = 4'd1;
                            default:  ;
                        endcase
                    end
                end
            end
            ST_SEND: begin
                if (status.out_free) begin
                    ctrl.load_out = 1'b1;
                    if (ctrl.last) begin
                        state_next = ST_IDLE;
                    end else begin
                        idx_next = idx_reg + 4'd1;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    a_pay_idx_range: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.pay_wr |-> (ctrl.pay_idx < 4'(PayloadLen)))
        else $error("payload write index out of range");

    a_last_returns_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (ctrl.load_out && ctrl.last) |=> (state_reg == ST_IDLE))
        else $error("reply did not end after its last item");

    a_apply_initialized: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.apply |-> status.initialized)
        else $error("payload applied while not initialized");

    a_send_idx_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SEND) |-> (idx_reg < reply_len(reply_reg)))
        else $error("reply index past reply length");

endmodule

FILE: rtl/scr_dp.sv
// datapath: sensor stores, payload buffer, references and output register
module scr_dp (
    input  logic                aclk,
    input  logic                aresetn,
    input  scr_pkg::in_item_t   s_data,
    input  scr_pkg::dp_ctrl_t   ctrl,
    output scr_pkg::dp_status_t status,
    output logic                m_valid,
    input  logic                m_ready,
    output scr_pkg::out_item_t  m_data
);
    import scr_pkg::*;

    logic [7:0]  payload_reg [PayloadLen];
    logic [7:0]  home_lo_reg [NumAxes];
    logic [7:0]  temp_lo_reg [NumAxes];
    logic [31:0] curr_reg    [NumAxes];
    logic [31:0] angle_reg   [NumAxes];
    logic        init_reg;
    logic [31:0] ref_one_reg, ref_two_reg;
    logic        close_reg, open_reg;
    logic        m_valid_reg;
    out_item_t   m_data_reg;

    logic        axis_ok;
    logic        zero_hi;
    logic        code_close, code_open;
    logic [7:0]  tx_byte;
    logic [31:0] word_sel;
    logic [1:0]  axis_sel;

    assign axis_ok = (s_data.axis < 2'(NumAxes));

    assign status.is_rx       = (s_data.req_type == REQ_RX_BYTE);
    assign status.cmd         = decode_cmd(s_data.rx_byte);
    assign status.initialized = init_reg;
    assign status.out_free    = !m_valid_reg || m_ready;

    // last code byte is the one arriving now
    assign zero_hi    = (payload_reg[8] == 8'd0) && (payload_reg[9] == 8'd0);
    assign code_close = zero_hi && (payload_reg[10] == 8'd0) && (s_data.rx_byte == 8'd1);
    assign code_open  = zero_hi && (payload_reg[10] == 8'd1) && (s_data.rx_byte == 8'd0);

    always_ff @(posedge aclk) begin
        if (ctrl.pay_wr) begin
            payload_reg[ctrl.pay_idx] <= s_data.rx_byte;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int a = 0; a < NumAxes; a++) begin
                home_lo_reg[a] <= '0;
                temp_lo_reg[a] <= '0;
                curr_reg[a]    <= '0;
                angle_reg[a]   <= '0;
            end
            init_reg    <= 1'b0;
            ref_one_reg <= '0;
            ref_two_reg <= '0;
            close_reg   <= 1'b0;
            open_reg    <= 1'b0;
        end else begin
            if (ctrl.take && axis_ok) begin
                case (s_data.req_type)
                    REQ_HOME_SW: home_lo_reg[s_data.axis] <= s_data.sensor_word[7:0] & LowByteMask;
                    REQ_TEMP:    temp_lo_reg[s_data.axis] <= s_data.sensor_word[7:0] & LowByteMask;
                    REQ_CURRENT: curr_reg[s_data.axis]    <= s_data.sensor_word;
                    REQ_ANGLE:   angle_reg[s_data.axis]   <= s_data.sensor_word;
                    default:     ;
                endcase
            end
            if (ctrl.take && (s_data.req_type == REQ_HOME_DONE)) begin
                init_reg <= 1'b1;
            end else if (ctrl.clear_init) begin
                init_reg <= 1'b0;
            end
            if (ctrl.apply) begin
                ref_one_reg <= {payload_reg[0], payload_reg[1], payload_reg[2], payload_reg[3]};
                ref_two_reg <= {payload_reg[4], payload_reg[5], payload_reg[6], payload_reg[7]};
                if (code_close) begin
                    close_reg <= 1'b1;
                end else if (code_open) begin
                    open_reg <= 1'b1;
                end else begin
                    close_reg <= 1'b0;
                    open_reg  <= 1'b0;
                end
            end
        end
    end

    // reply byte select: words go out per axis, low byte first
    always_comb begin
        axis_sel = (ctrl.reply == RPL_CURR || ctrl.reply == RPL_ANGLE) ?
                   ctrl.idx[3:2] : ctrl.idx[1:0];
        word_sel = '0;
        case (ctrl.reply)
            RPL_HOME:  word_sel = {24'd0, home_lo_reg[axis_sel]};
            RPL_TEMP:  word_sel = {24'd0, temp_lo_reg[axis_sel]};
            RPL_CURR:  word_sel = curr_reg[axis_sel];
            RPL_ANGLE: word_sel = angle_reg[axis_sel];
            default:   word_sel = '0;
        endcase
        if (ctrl.reply == RPL_CURR || ctrl.reply == RPL_ANGLE) begin
            tx_byte = word_sel[8 * ctrl.idx[1:0] +: 8];
        end else begin
            tx_byte = word_sel[7:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (ctrl.load_out) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.load_out) begin
            m_data_reg.tx_valid       <= (ctrl.reply != RPL_INIT) && (ctrl.reply != RPL_REF);
            m_data_reg.tx_byte        <= ((ctrl.reply != RPL_INIT) && (ctrl.reply != RPL_REF))
                                         ? tx_byte : 8'd0;
            m_data_reg.ref_valid      <= (ctrl.reply == RPL_REF);
            m_data_reg.angle_ref_one  <= ref_one_reg;
            m_data_reg.angle_ref_two  <= ref_two_reg;
            m_data_reg.close_cmd      <= close_reg;
            m_data_reg.open_cmd       <= open_reg;
            m_data_reg.homing_request <= (ctrl.reply == RPL_INIT);
            m_data_reg.last           <= ctrl.last;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_ready) |-> !ctrl.load_out)
        else $error("output register overwritten while held");

    a_no_take_while_sending: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.load_out |-> !ctrl.take)
        else $error("item taken during a reply");

endmodule

FILE: tb/scr_reply_checker_pkg.sv
// reply prediction and checking for the serial command responder testbench
package scr_reply_checker_pkg;
    import scr_pkg::*;

    // gripper codes as they read big-endian from payload bytes 8..11
    localparam logic [31:0] GripClose = 32'h0000_0001;
    localparam logic [31:0] GripOpen  = 32'h0000_0100;

    class reply_checker;
        int        fails;
        out_item_t awaited [$];

        // mirror of the block state
        bit [3:0]  rx_phase;
        bit [7:0]  payload [PayloadLen];
        bit [7:0]  home_lo [NumAxes];
        bit [7:0]  temp_lo [NumAxes];
        bit [31:0] current_w [NumAxes];
        bit [31:0] angle_w [NumAxes];
        bit        homed;
        bit [31:0] ref_w [2];
        bit [1:0]  grip;

        function int pending();
            return awaited.size();
        endfunction

        function void add_reply(bit txv, bit [7:0] txb, bit refv, bit home);
            out_item_t r;
            r.tx_valid       = txv;
            r.tx_byte        = txb;
            r.ref_valid      = refv;
            r.angle_ref_one  = ref_w[0];
            r.angle_ref_two  = ref_w[1];
            r.close_cmd      = grip[0];
            r.open_cmd       = grip[1];
            r.homing_request = home;
            r.last           = 1'b0;
            awaited.push_back(r);
        endfunction

        // three words, each least significant byte first
        function void add_words(input bit [31:0] w [NumAxes]);
            for (int a = 0; a < NumAxes; a++) begin
                for (int b = 0; b < 4; b++) begin
                    add_reply(1'b1, w[a][8*b +: 8], 1'b0, 1'b0);
                end
            end
        endfunction

        function void apply_ref();
            bit [31:0] code;
            if (!homed) begin
                return;
            end
            ref_w[0] = {payload[0], payload[1], payload[2], payload[3]};
            ref_w[1] = {payload[4], payload[5], payload[6], payload[7]};
            code     = {payload[8], payload[9], payload[10], payload[11]};
            if (code == GripClose) begin
                grip[0] = 1'b1;
            end else if (code == GripOpen) begin
                grip[1] = 1'b1;
            end else begin
                grip = 2'b00;
            end
            add_reply(1'b0, 8'h00, 1'b1, 1'b0);
        endfunction

        function void take_byte(bit [7:0] b);
            // while collecting, every byte is payload data
            if (rx_phase >= 1 && rx_phase <= PayloadLen) begin
                payload[rx_phase - 1] = b;
                if (rx_phase == PayloadLen) begin
                    rx_phase = 0;
                    apply_ref();
                end else begin
                    rx_phase++;
                end
                return;
            end
            rx_phase = 0;
            case (b)
                CharInit: begin
                    homed = 1'b0;
                    add_reply(1'b0, 8'h00, 1'b0, 1'b1);
                end
                CharHome: begin
                    for (int a = 0; a < NumAxes; a++) add_reply(1'b1, home_lo[a], 1'b0, 1'b0);
                end
                CharTemp: begin
                    for (int a = 0; a < NumAxes; a++) add_reply(1'b1, temp_lo[a], 1'b0, 1'b0);
                end
                CharCurr:  add_words(current_w);
                CharAngle: add_words(angle_w);
                CharRef:   rx_phase = 1;
                default: ;
            endcase
        endfunction

        function void note_item(in_item_t it);
            int        n_prior;
            out_item_t tail;
            n_prior = awaited.size();
            case (it.req_type)
                REQ_RX_BYTE:   take_byte(it.rx_byte);
                REQ_HOME_SW:   if (it.axis < NumAxes) home_lo[it.axis] = it.sensor_word[7:0];
                REQ_TEMP:      if (it.axis < NumAxes) temp_lo[it.axis] = it.sensor_word[7:0];
                REQ_CURRENT:   if (it.axis < NumAxes) current_w[it.axis] = it.sensor_word;
                REQ_ANGLE:     if (it.axis < NumAxes) angle_w[it.axis] = it.sensor_word;
                REQ_HOME_DONE: homed = 1'b1;
                default: ;
            endcase
            if (awaited.size() > n_prior) begin
                tail = awaited.pop_back();
                tail.last = 1'b1;
                awaited.push_back(tail);
            end
        endfunction

        function bit field_ok(string name, logic [31:0] want, logic [31:0] seen);
            if (want !== seen) begin
                $display("%0t: %s mismatch: expected %0h, got %0h", $time, name, want, seen);
                return 1'b0;
            end
            return 1'b1;
        endfunction

        function void check_reply(out_item_t seen);
            out_item_t want;
            bit        ok;
            if (awaited.size() == 0) begin
                $display("%0t: unexpected reply: expected none, got %h", $time, seen);
                fails++;
                return;
            end
            want = awaited.pop_front();
            ok = 1'b1;
            ok &= field_ok("tx_valid", want.tx_valid, seen.tx_valid);
            ok &= field_ok("tx_byte", want.tx_byte, seen.tx_byte);
            ok &= field_ok("ref_valid", want.ref_valid, seen.ref_valid);
            ok &= field_ok("angle_ref_one", want.angle_ref_one, seen.angle_ref_one);
            ok &= field_ok("angle_ref_two", want.angle_ref_two, seen.angle_ref_two);
            ok &= field_ok("close_cmd", want.close_cmd, seen.close_cmd);
            ok &= field_ok("open_cmd", want.open_cmd, seen.open_cmd);
            ok &= field_ok("homing_request", want.homing_request, seen.homing_request);
            ok &= field_ok("last", want.last, seen.last);
            if (!ok) begin
                fails++;
            end
        endfunction
    endclass

endpackage

FILE: tb/serial_command_responder_core_tb.sv
// testbench for serial_command_responder_core: random command streams checked against predicted replies
module serial_command_responder_core_tb;
    import scr_pkg::*;
    import scr_reply_checker_pkg::*;

    localparam int HoldCycles = 150;
    localparam int BurstItems = 30;

    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_item_t  s_data  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_item_t m_data;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_requests = 0;
    int holds_taken   = 0;
    int hold_left     = 0;
    int items_sent    = 0;

    reply_checker replies = new();

    serial_command_responder_core uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always #6 aclk = ~aclk;

    // reply side: check what was taken at this edge, then pick the next ready
    always @(posedge aclk) begin
        if (m_valid && m_ready) begin
            replies.check_reply(m_data);
        end
        if (holds_taken != hold_requests) begin
            holds_taken = hold_requests;
            hold_left = HoldCycles;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= aresetn && ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic send_item(input in_item_t it);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        replies.note_item(it);
        items_sent++;
    endtask

    task automatic send_byte(input logic [7:0] b);
        in_item_t it;
        it.req_type    = REQ_RX_BYTE;
        it.axis        = 2'($urandom);
        it.sensor_word = $urandom;
        it.rx_byte     = b;
        send_item(it);
    endtask

    task automatic send_update(input logic [2:0] kind, input logic [1:0] ax, input logic [31:0] w);
        in_item_t it;
        it.req_type    = kind;
        it.axis        = ax;
        it.sensor_word = w;
        it.rx_byte     = 8'($urandom);
        send_item(it);
    endtask

    function automatic logic [1:0] rand_axis();
        return ($urandom_range(9) == 0) ? 2'd3 : 2'($urandom_range(NumAxes - 1));
    endfunction

    function automatic logic [31:0] rand_grip_code();
        case ($urandom_range(3))
            0: return GripClose;
            1: return GripOpen;
            2: return GripClose ^ (32'd1 << $urandom_range(31)); // near miss
            default: return $urandom;
        endcase
    endfunction

    // 'R' followed by its 12 payload bytes, sensor updates optionally mixed in
    task automatic send_ref(input logic [31:0] w0, input logic [31:0] w1,
                            input logic [31:0] code, input bit mixed);
        logic [95:0] body;
        body = {w0, w1, code};
        send_byte(CharRef);
        for (int i = 0; i < PayloadLen; i++) begin
            if (mixed && $urandom_range(3) == 0) begin
                send_update(3'($urandom_range(REQ_HOME_SW, REQ_ANGLE)), rand_axis(), $urandom);
            end
            send_byte(body[95 - 8*i -: 8]);
        end
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (replies.pending() != 0) @(posedge aclk);
    endtask

    task automatic random_burst(input int n_items);
        int         stop_at;
        int         pick;
        logic [7:0] letter;
        stop_at = items_sent + n_items;
        while (items_sent < stop_at) begin
            pick = $urandom_range(99);
            if (pick < 35) begin
                send_update(3'($urandom_range(REQ_HOME_SW, REQ_ANGLE)), rand_axis(), $urandom);
            end else if (pick < 60) begin
                case ($urandom_range(9))
                    0:       letter = CharInit;
                    1, 2:    letter = CharHome;
                    3, 4:    letter = CharTemp;
                    5, 6:    letter = CharCurr;
                    default: letter = CharAngle;
                endcase
                send_byte(letter);
            end else if (pick < 78) begin
                send_ref($urandom, $urandom, rand_grip_code(), $urandom_range(2) == 0);
            end else if (pick < 86) begin
                send_update(REQ_HOME_DONE, rand_axis(), $urandom);
            end else if (pick < 94) begin
                send_byte(8'($urandom));
            end else begin
                send_update(3'($urandom_range(REQ_HOME_DONE + 1, 7)), rand_axis(), $urandom);
            end
        end
    endtask

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // sensor extremes, ignored axis and request types, every command
        send_update(REQ_HOME_SW, 2'd0, 32'hFFFF_FFFF);
        send_update(REQ_TEMP, 2'd2, 32'h0000_0080);
        send_update(REQ_CURRENT, 2'd1, 32'hFFFF_FFFF);
        send_update(REQ_ANGLE, 2'd2, 32'h8000_0001);
        send_update(REQ_ANGLE, 2'd3, 32'h1234_5678);
        send_update(3'(REQ_HOME_DONE + 1), 2'd0, 32'h0);
        send_update(3'(REQ_HOME_DONE + 2), 2'd3, 32'hFFFF_FFFF);
        send_byte(CharHome);
        send_byte(CharTemp);
        send_byte(CharCurr);
        send_byte(CharAngle);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(CharInit);
        send_update(REQ_HOME_DONE, 2'd0, 32'h0);
        // command letters inside a payload are plain data
        send_ref({CharInit, CharRef, CharHome, 8'hFF}, 32'h0000_0000, GripClose, 1'b0);

        send_idle_pct = 17;
        recv_idle_pct = 65;
        random_burst(BurstItems);
        send_idle_pct = 65;
        recv_idle_pct = 17;
        random_burst(BurstItems);
        send_idle_pct = 0;
        recv_idle_pct = 0;

        // long reply stall while long replies keep being requested
        hold_requests++;
        send_byte(CharCurr);
        send_byte(CharAngle);
        send_byte(CharCurr);
        send_byte(CharHome);
        wait_drained();

        random_burst(BurstItems);
        wait_drained();
        repeat (40) @(posedge aclk);

        if (replies.fails == 0 && replies.pending() == 0) begin
            $display("serial_command_responder_core_tb: PASS");
        end else begin
            $display("serial_command_responder_core_tb: FAIL");
        end
        $finish;
    end

    initial begin
        #(12 * 400000);
        $display("serial_command_responder_core_tb: FAIL");
        $finish;
    end

endmodule
